// ===== rtl/hysteresis_threshold_3x3_assert.svh =====
// ----------------------------------------------------------------------------
// hysteresis_threshold_3x3 assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_THRESHOLD_3X3_ASSERT_SVH
`define HYSTERESIS_THRESHOLD_3X3_ASSERT_SVH

// same-cycle implication, masked while reset is asserted
`define HTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hysteresis_threshold_3x3 port check failed");

// next-cycle implication, masked while reset is asserted
`define HTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hysteresis_threshold_3x3 port check failed");

// next-cycle implication that also runs through reset
`define HTT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hysteresis_threshold_3x3 port check failed");

`endif

// ===== rtl/htt_pkg.sv =====
// ----------------------------------------------------------------------------
// htt_pkg
// Types, codes and helpers shared by the hysteresis threshold block.
// ----------------------------------------------------------------------------
`default_nettype none

package htt_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_W = 11;  // widest config register
    localparam int PIX_W = 8;

    localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

    localparam logic [PIX_W-1:0] RST_LOW_THR  = 8'd50;
    localparam logic [PIX_W-1:0] RST_HIGH_THR = 8'd150;
    localparam logic [CFG_W-1:0] RST_IMG_DIM  = 11'd1024;

    typedef enum logic [1:0] {
        CFG_LOW_THR    = 2'd0,
        CFG_HIGH_THR   = 2'd1,
        CFG_IMG_WIDTH  = 2'd2,
        CFG_IMG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CLS_ZERO   = 2'd0,
        CLS_WEAK   = 2'd1,
        CLS_STRONG = 2'd2
    } t_cls;

    // one column of the two line stores: row y-2 and row y-1
    typedef struct packed {
        t_cls top;
        t_cls mid;
    } t_col_entry;

    // which neighbor rows/columns lie inside the frame
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_edge;

    typedef struct packed {
        logic             eof;
        logic [PIX_W-1:0] pix;
    } t_out_item;

    function automatic t_cls classify(input logic [PIX_W-1:0] pix,
                                      input logic [PIX_W-1:0] lo,
                                      input logic [PIX_W-1:0] hi);
        t_cls c;
        if (pix <= lo) begin
            c = CLS_ZERO;
        end else if (pix >= hi) begin
            c = CLS_STRONG;
        end else begin
            c = CLS_WEAK;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/htt_line_ram.sv =====
// ----------------------------------------------------------------------------
// htt_line_ram
// Simple dual-port line store: one write and one registered read per cycle.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 4,
    parameter int AW     = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/hysteresis_threshold_3x3.sv =====
// ----------------------------------------------------------------------------
// hysteresis_threshold_3x3
// Single-pass 3x3 hysteresis thresholding of a raster stream of grey pixels.
//
// Takes one item per clock while the output queue has room. Each pixel is
// classed zero/weak/strong and its class goes into a line store RAM (one
// column entry holds the two previous rows) that is read and written back
// once per item; a 3x3 class window follows the RAM read. A result passes
// through stage 1 and the output queue. Results lag the input by one row
// plus one pixel, so after the last pixel of a frame width + 1 drain items
// (tuser = 1) flush the rest; the last result of a frame carries tlast. Frame
// size is taken from the config registers when the first pixel of a frame
// arrives. A four-entry output queue absorbs back-pressure; input stalls
// once the queue entries plus the item one stage behind the input reach
// four. The line store is not cleared after reset: it holds only rows of
// the current frame before they are used.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_threshold_3x3
    import htt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input item
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [PIX_W-1:0]            s_axis_tdata,   // [7:0] pixel_in
    input  wire logic [0:0]                  s_axis_tuser,   // [0] kind
    // result item
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [PIX_W-1:0]            m_axis_tdata,   // [7:0] pixel_out
    output logic                             m_axis_tlast,   // end_of_frame
    // config
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [$bits(t_cfg_idx)-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]            i_cfg_wdata
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int QW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
    localparam int CWW  = (WW > CFG_W) ? WW : CFG_W;
    localparam int CWH  = (HW > CFG_W) ? HW : CFG_W;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 2);

    // ---------------- config registers ----------------
    logic [PIX_W-1:0] r_low_thr, r_high_thr;
    logic [CFG_W-1:0] r_img_w, r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= RST_LOW_THR;
            r_high_thr <= RST_HIGH_THR;
            r_img_w    <= RST_IMG_DIM;
            r_img_h    <= RST_IMG_DIM;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOW_THR:    r_low_thr  <= i_cfg_wdata[PIX_W-1:0];
                CFG_HIGH_THR:   r_high_thr <= i_cfg_wdata[PIX_W-1:0];
                CFG_IMG_WIDTH:  r_img_w    <= i_cfg_wdata;
                CFG_IMG_HEIGHT: r_img_h    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame size saturated to 1..MAX
    logic [WW-1:0] clamp_w;
    logic [HW-1:0] clamp_h;

    always_comb begin
        if (r_img_w == '0) begin
            clamp_w = WW'(1);
        end else if (CWW'(r_img_w) > CWW'(MAX_WIDTH)) begin
            clamp_w = WW'(MAX_WIDTH);
        end else begin
            clamp_w = WW'(r_img_w);
        end
        if (r_img_h == '0) begin
            clamp_h = HW'(1);
        end else if (CWH'(r_img_h) > CWH'(MAX_HEIGHT)) begin
            clamp_h = HW'(MAX_HEIGHT);
        end else begin
            clamp_h = HW'(r_img_h);
        end
    end

    // ---------------- stream position ----------------
    logic          r_started;
    logic [WW-1:0] r_fw;
    logic [HW-1:0] r_fh;
    logic [QW-1:0] r_total;
    logic [AW-1:0] r_col;     // column of next input slot
    logic [QW-1:0] r_q;       // slots since frame start
    logic [QW-1:0] r_p;       // raster index of next result
    logic [WW-1:0] r_ocol;
    logic [HW-1:0] r_orow;

    logic          acc, is_pix, latch, in_frame, step, emit, eof;
    logic [WW-1:0] fw_cur;
    logic [AW-1:0] n_col;
    logic [WW-1:0] n_ocol;
    logic [HW-1:0] n_orow;
    t_cls          cn;
    t_edge         edge_ok;

    assign acc    = s_axis_tvalid && s_axis_tready;
    assign is_pix = (t_kind'(s_axis_tuser[0]) == KIND_PIXEL);
    assign latch  = acc && is_pix && (r_q == '0);
    assign fw_cur = latch ? clamp_w : r_fw;
    assign in_frame = latch || (r_q < r_total);
    // a drain tick before the last pixel does nothing
    assign step   = acc && (latch || r_started) && (is_pix || !in_frame);
    assign cn     = (in_frame && is_pix) ? classify(s_axis_tdata, r_low_thr, r_high_thr)
                                         : CLS_ZERO;
    assign emit   = (r_q >= (QW'(fw_cur) + QW'(1)));
    assign eof    = emit && ((r_p + QW'(1)) >= r_total);

    assign n_col  = ((WW'(r_col) + WW'(1)) >= fw_cur) ? '0 : (r_col + AW'(1));

    always_comb begin
        n_ocol = r_ocol + WW'(1);
        n_orow = r_orow;
        if (n_ocol >= r_fw) begin
            n_ocol = '0;
            n_orow = r_orow + HW'(1);
        end
    end

    assign edge_ok.top_ok   = (r_orow != '0);
    assign edge_ok.bot_ok   = ((r_orow + HW'(1)) < r_fh);
    assign edge_ok.left_ok  = (r_ocol != '0);
    assign edge_ok.right_ok = ((r_ocol + WW'(1)) < r_fw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_fw      <= '0;
            r_fh      <= '0;
            r_total   <= '0;
            r_col     <= '0;
            r_q       <= '0;
            r_p       <= '0;
            r_ocol    <= '0;
            r_orow    <= '0;
        end else if (step) begin
            if (latch) begin
                r_started <= 1'b1;
                r_fw      <= clamp_w;
                r_fh      <= clamp_h;
                r_total   <= QW'(clamp_w) * QW'(clamp_h);
            end
            if (eof) begin
                r_col  <= '0;
                r_q    <= '0;
                r_p    <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else begin
                r_col <= n_col;
                r_q   <= r_q + QW'(1);
                if (emit) begin
                    r_p    <= r_p + QW'(1);
                    r_ocol <= n_ocol;
                    r_orow <= n_orow;
                end
            end
        end
    end

    // ---------------- line store ----------------
    logic                     r_s1_valid;
    logic                     r_s1_emit, r_s1_eof, r_s1_hz;
    t_cls                     r_s1_cn;
    logic [AW-1:0]            r_s1_x;
    t_edge                    r_s1_edge;
    t_col_entry               r_s1_fwd;
    t_col_entry               s1_rd, s1_wr;
    logic [$bits(t_col_entry)-1:0] ram_rdata;

    htt_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W ($bits(t_col_entry))
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_x),
        .i_wr_data (s1_wr),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rdata)
    );

    // same column written back while being read: take the written value
    assign s1_rd     = r_s1_hz ? r_s1_fwd : t_col_entry'(ram_rdata);
    assign s1_wr.top = s1_rd.mid;
    assign s1_wr.mid = r_s1_cn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_emit <= emit;
        r_s1_eof  <= eof;
        r_s1_cn   <= cn;
        r_s1_x    <= r_col;
        r_s1_edge <= edge_ok;
        r_s1_hz   <= r_s1_valid && (r_s1_x == r_col);
        r_s1_fwd  <= s1_wr;
    end

    // ---------------- 3x3 window ----------------
    t_cls             r_win [3][3];
    t_cls             nw    [3][3];
    logic [2:0]       row_ok, col_ok;
    logic             strong_nb;
    logic [PIX_W-1:0] s1_pix;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            nw[r][0] = r_win[r][1];
            nw[r][1] = r_win[r][2];
        end
        nw[0][2] = s1_rd.top;
        nw[1][2] = s1_rd.mid;
        nw[2][2] = r_s1_cn;
    end

    assign row_ok = {r_s1_edge.bot_ok, 1'b1, r_s1_edge.top_ok};
    assign col_ok = {r_s1_edge.right_ok, 1'b1, r_s1_edge.left_ok};

    always_comb begin
        strong_nb = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_ok[r] && col_ok[c] && (nw[r][c] == CLS_STRONG)) begin
                    strong_nb = 1'b1;
                end
            end
        end
    end

    assign s1_pix = ((nw[1][1] == CLS_STRONG) || ((nw[1][1] == CLS_WEAK) && strong_nb))
                    ? PIX_ON : PIX_OFF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= CLS_ZERO;
                end
            end
        end else if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= nw[r][c];
                end
            end
        end
    end

    // ---------------- output queue ----------------
    t_out_item        r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wr, r_oq_rd;
    logic [OQ_CW-1:0] r_oq_cnt;
    logic             push, pop;
    t_out_item        oq_head;

    assign push = r_s1_valid && r_s1_emit;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_oq[r_oq_wr] <= '{eof: r_s1_eof, pix: s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (push) begin
                r_oq_wr <= r_oq_wr + OQ_AW'(1);
            end
            if (pop) begin
                r_oq_rd <= r_oq_rd + OQ_AW'(1);
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(push) - OQ_CW'(pop);
        end
    end

    // an item in stage 1 may still need a slot
    assign s_axis_tready = ((r_oq_cnt + OQ_CW'(r_s1_valid)) < OQ_CW'(OQ_DEPTH));

    assign oq_head       = r_oq[r_oq_rd];
    assign m_axis_tvalid = (r_oq_cnt != '0);
    assign m_axis_tdata  = oq_head.pix;
    assign m_axis_tlast  = oq_head.eof;

endmodule

`default_nettype wire

// ===== rtl/htt_checker.sv =====
// ----------------------------------------------------------------------------
// htt_checker
// Port-level checks for hysteresis_threshold_3x3, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hysteresis_threshold_3x3_assert.svh"

module htt_checker
    import htt_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [PIX_W-1:0] m_axis_tdata,   // [7:0] pixel_out
    input wire logic             m_axis_tlast
);

    logic           in_acc, out_wait, pix_ok;
    logic [PIX_W:0] out_word;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign pix_ok   = (m_axis_tdata == PIX_ON) || (m_axis_tdata == PIX_OFF);
    assign out_word = {m_axis_tlast, m_axis_tdata};

    // results are binary images
    `HTT_ASSERT_IMPL(a_pix_binary, i_clk, i_rst_n, m_axis_tvalid, pix_ok)

    // stalled result holds
    `HTT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, m_axis_tvalid && $stable(out_word))

    // an empty queue only fills from an item taken in that has passed stage 1
    `HTT_ASSERT_IMPL(a_out_after_in, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(in_acc, 2))

    // reset empties the output side
    `HTT_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind hysteresis_threshold_3x3 htt_checker u_htt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: hysteresis_threshold_3x3 testbench
// Streams raster frames (pixels plus drain slots) into the block and checks
// every thresholded output pixel and its end-of-frame flag against an
// in-bench model of the class line stores and 3x3 window. It covers directed
// edge cases, geometry and threshold extremes, long output back-pressure,
// and random frames with noise slots and mid-frame register updates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import htt_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 440;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [PIX_W-1:0]            s_axis_tdata  = '0;   // [7:0] pixel_in
    logic [0:0]                  s_axis_tuser  = '0;   // [0] kind
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [PIX_W-1:0]            m_axis_tdata;         // [7:0] pixel_out
    logic                        m_axis_tlast;
    logic                        i_cfg_wr_en   = 1'b0;
    logic [$bits(t_cfg_idx)-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]            i_cfg_wdata   = '0;

    // register shadow and model state
    logic [PIX_W-1:0] thr_lo = RST_LOW_THR;
    logic [PIX_W-1:0] thr_hi = RST_HIGH_THR;
    logic [CFG_W-1:0] cfg_w  = RST_IMG_DIM;
    logic [CFG_W-1:0] cfg_h  = RST_IMG_DIM;
    t_cls             line_cls [2*DEF_MAX_WIDTH];
    t_cls             win [3][3];
    int unsigned      in_col, in_row, out_pos, frm_w, frm_h;
    t_out_item        expected_px [$];

    int errors      = 0;
    int idle_cycles = 0;
    int frame_items = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;

    hysteresis_threshold_3x3 dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v, input int unsigned cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic t_cls grade(input logic [PIX_W-1:0] pix);
        if (pix <= thr_lo) return CLS_ZERO;
        if (pix >= thr_hi) return CLS_STRONG;
        return CLS_WEAK;
    endfunction

    // advance the model by one accepted item, queue the output it releases
    function automatic void hysteresis_predict(input t_kind kind, input logic [PIX_W-1:0] pix);
        int unsigned total, slot, p, orow, ocol;
        t_cls        nc, above, center_row;
        t_out_item   res;
        bit          top_in, bot_in, left_in, right_in;
        if (in_col == 0 && in_row == 0 && kind == KIND_PIXEL) begin
            frm_w = fit_dim(cfg_w, DEF_MAX_WIDTH);
            frm_h = fit_dim(cfg_h, DEF_MAX_HEIGHT);
        end
        if (frm_w == 0) return;
        total = frm_w * frm_h;
        slot  = in_row * frm_w + in_col;
        if (kind == KIND_DRAIN && slot < total) return;
        nc = (slot < total && kind == KIND_PIXEL) ? grade(pix) : CLS_ZERO;

        above      = line_cls[in_col];
        center_row = line_cls[DEF_MAX_WIDTH + in_col];
        line_cls[in_col]                 = center_row;
        line_cls[DEF_MAX_WIDTH + in_col] = nc;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = above;
        win[1][2] = center_row;
        win[2][2] = nc;

        in_col++;
        if (in_col >= frm_w) begin
            in_col = 0;
            in_row++;
        end
        if (slot < frm_w + 1) return;

        p        = out_pos;
        orow     = p / frm_w;
        ocol     = p % frm_w;
        top_in   = (orow != 0);
        bot_in   = (orow + 1 < frm_h);
        left_in  = (ocol != 0);
        right_in = (ocol + 1 < frm_w);
        res.pix  = PIX_OFF;
        if (win[1][1] == CLS_STRONG) begin
            res.pix = PIX_ON;
        end else if (win[1][1] == CLS_WEAK) begin
            // neighbors off the frame, wrapped ones too, do not count
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if ((r != 0 || top_in) && (r != 2 || bot_in) &&
                        (c != 0 || left_in) && (c != 2 || right_in) &&
                        win[r][c] == CLS_STRONG) begin
                        res.pix = PIX_ON;
                    end
                end
            end
        end
        res.eof = (p + 1 >= total);
        if (res.eof) begin
            in_col  = 0;
            in_row  = 0;
            out_pos = 0;
        end else begin
            out_pos = p + 1;
        end
        expected_px.push_back(res);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // ---------------- output side ----------------
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_px.size() == 0) begin
                flag_mismatch($sformatf("pixel %0d last %0b with nothing expected",
                                        m_axis_tdata, m_axis_tlast));
            end else begin
                want = expected_px.pop_front();
                if (m_axis_tdata !== want.pix)
                    flag_mismatch($sformatf("pixel got %0d want %0d", m_axis_tdata, want.pix));
                if (m_axis_tlast !== want.eof)
                    flag_mismatch($sformatf("tlast got %0b want %0b", m_axis_tlast, want.eof));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("hysteresis_threshold_3x3 verification failed");
            $finish;
        end
    end

    // ---------------- input side ----------------
    task automatic send_item(input t_kind kind, input logic [PIX_W-1:0] pix);
        while (!calm && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        hysteresis_predict(kind, pix);
    endtask

    // stop offering, wait for every expected output, let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_put(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LOW_THR:    thr_lo = val[PIX_W-1:0];
            CFG_HIGH_THR:   thr_hi = val[PIX_W-1:0];
            CFG_IMG_WIDTH:  cfg_w  = val;
            CFG_IMG_HEIGHT: cfg_h  = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi,
                                input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        cfg_put(CFG_LOW_THR, CFG_W'(lo));
        cfg_put(CFG_HIGH_THR, CFG_W'(hi));
        cfg_put(CFG_IMG_WIDTH, w);
        cfg_put(CFG_IMG_HEIGHT, h);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_regs();
        logic [PIX_W-1:0] lo, hi;
        logic [CFG_W-1:0] w, h;
        lo = 8'($urandom_range(0, 120));
        hi = 8'($urandom_range(90, 255));
        case ($urandom_range(7))
            0: begin
                lo = 8'($urandom);
                hi = 8'($urandom);
            end
            1: begin
                lo = PIX_OFF;
                hi = PIX_ON;
            end
            default: ;
        endcase
        w = CFG_W'($urandom_range(1, 12));
        h = CFG_W'($urandom_range(1, 8));
        if ($urandom_range(9) == 0) w = CFG_W'($urandom_range(13, 40));
        program_regs(lo, hi, w, h);
    endtask

    // values clustered on the thresholds so all three classes show up
    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] v;
        case ($urandom_range(9))
            0: v = PIX_OFF;
            1: v = PIX_ON;
            2: v = thr_lo;
            3: v = thr_lo + 8'd1;
            4: v = thr_hi;
            5: v = thr_hi - 8'd1;
            6: v = 8'($urandom);
            default: v = 8'($urandom_range(thr_lo, thr_hi));
        endcase
        return v;
    endfunction

    // one frame at the current geometry: pixels, then width + 1 drain slots;
    // noisy frames add ignored drains, pixels as drain slots and register updates
    task automatic run_frame(input bit noisy);
        int unsigned fw, fh;
        fw = fit_dim(cfg_w, DEF_MAX_WIDTH);
        fh = fit_dim(cfg_h, DEF_MAX_HEIGHT);
        for (int unsigned i = 0; i < fw * fh; i++) begin
            if (noisy && $urandom_range(9) == 0) send_item(KIND_DRAIN, 8'($urandom));
            if (noisy && i != 0 && $urandom_range(59) == 0) random_regs();
            send_item(KIND_PIXEL, pick_pixel());
        end
        for (int unsigned i = 0; i <= fw; i++) begin
            if (noisy && $urandom_range(3) == 0)
                send_item(KIND_PIXEL, 8'($urandom));
            else
                send_item(KIND_DRAIN, 8'($urandom));
        end
        frame_items += fw * fh + fw + 1;
    endtask

    // ---------------- tests ----------------
    task automatic test_drain_at_reset();
        // no frame has started yet, nothing to flush
        send_item(KIND_DRAIN, PIX_ON);
    endtask

    task automatic test_classes();
        logic [PIX_W-1:0] pxs [12];
        pxs = '{8'd0, 8'd50, 8'd51, 8'd255, 8'd149, 8'd100,
                8'd100, 8'd60, 8'd255, 8'd150, 8'd51, 8'd149};
        program_regs(RST_LOW_THR, RST_HIGH_THR, 11'd4, 11'd3);
        foreach (pxs[i]) begin
            send_item(KIND_PIXEL, pxs[i]);
            if (i == 5) send_item(KIND_DRAIN, PIX_ON);   // mid-frame drain, ignored
        end
        send_item(KIND_PIXEL, PIX_ON);                   // pixel in a drain slot
        send_item(KIND_DRAIN, PIX_OFF);
        send_item(KIND_PIXEL, PIX_OFF);
        send_item(KIND_DRAIN, PIX_ON);
        send_item(KIND_DRAIN, PIX_OFF);
        send_item(KIND_DRAIN, PIX_ON);                   // after end of frame, ignored
    endtask

    task automatic test_crossed_thresholds();
        program_regs(8'd200, 8'd100, 11'd3, 11'd2);
        run_frame(1'b0);
        program_regs(PIX_ON, PIX_OFF, 11'd3, 11'd2);
        run_frame(1'b0);
        program_regs(PIX_OFF, PIX_ON, 11'd2, 11'd2);
        run_frame(1'b0);
        program_regs(PIX_OFF, PIX_OFF, 11'd3, 11'd3);
        run_frame(1'b0);
    endtask

    task automatic test_midframe_update();
        program_regs(8'd60, 8'd140, 11'd5, 11'd4);
        repeat (10) send_item(KIND_PIXEL, pick_pixel());
        // thresholds act at once, geometry only from the next frame
        program_regs(8'd20, 8'd220, 11'd3, 11'd2);
        repeat (10) send_item(KIND_PIXEL, pick_pixel());
        repeat (6) send_item(KIND_DRAIN, PIX_OFF);
        run_frame(1'b0);
    endtask

    task automatic test_geometry_extremes();
        calm = 1'b1;
        program_regs(8'd80, 8'd160, 11'd0, 11'd0);        // saturates to 1 x 1
        run_frame(1'b0);
        program_regs(8'd80, 8'd160, 11'd1, 11'd40);       // single column
        run_frame(1'b0);
        program_regs(8'd80, 8'd160, 11'd40, 11'd1);       // single row
        run_frame(1'b0);
        program_regs(8'd80, 8'd160, 11'd12, 11'd8);
        run_frame(1'b0);
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        calm = 1'b1;
        program_regs(8'd60, 8'd140, 11'd8, 11'd6);
        hold_req = 1'b1;
        run_frame(1'b0);
        calm = 1'b0;
    endtask

    task automatic test_random_frames();
        int start;
        start = frame_items;
        while (frame_items - start < RANDOM_ITEMS) begin
            if ($urandom_range(2) == 0) random_regs();
            run_frame($urandom_range(4) == 0);
        end
    endtask

    initial begin
        foreach (line_cls[k]) line_cls[k] = CLS_ZERO;
        foreach (win[r, c]) win[r][c] = CLS_ZERO;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_drain_at_reset();
        test_classes();
        test_crossed_thresholds();
        test_midframe_update();
        test_geometry_extremes();
        test_backpressure();
        test_random_frames();

        settle();
        repeat (16) @(posedge i_clk);
        if (errors == 0)
            $display("hysteresis_threshold_3x3 verification clean");
        else
            $display("hysteresis_threshold_3x3 verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== hysteresis_threshold_3x3.f =====
+incdir+rtl
rtl/htt_pkg.sv
rtl/htt_line_ram.sv
rtl/hysteresis_threshold_3x3.sv
rtl/htt_checker.sv
test/tb_top.sv
